[src/hmv_pkg.sv]
// Shared types and constants for the int8 matrix-vector offset/scale block.
// No dependencies; every other file imports this package.
package hmv_pkg;

  localparam int VAL_W           = 8;
  localparam int DOT_W           = 28;
  localparam int SUM_W           = 20;
  localparam int SCALE_W         = 32;
  localparam int RES_W           = 64;
  localparam int SCALE_FRAC_BITS = 24;

  localparam int RSO_W  = SUM_W + VAL_W;
  localparam int CORR_W = ((DOT_W > RSO_W) ? DOT_W : RSO_W) + 1;
  localparam int PROD_W = DOT_W + SCALE_W + 1;

  // One closed row, handed from the accumulator front to the scaling back end
  typedef struct packed {
    logic signed [DOT_W-1:0]   dot;
    logic signed [SUM_W-1:0]   row_sum;
    logic signed [VAL_W-1:0]   zero_point;
    logic        [SCALE_W-1:0] batch_scale;
    logic        [SCALE_W-1:0] channel_scale;
    logic signed [RES_W-1:0]   prior_result;
  } hmv_row_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hmv_fifo_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CORR,
    B_SCALE,
    B_PROD,
    B_SUM,
    B_OUT
  } hmv_back_state_t;

endpackage

[src/hmv_if.sv]
// Valid/ready channel interfaces for the input pairs and the row results.
// Depends on hmv_pkg for field widths.
interface hmv_in_if import hmv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VAL_W-1:0]   matrix_value;
  logic signed [VAL_W-1:0]   vector_value;
  logic                      last_in_row;
  logic signed [VAL_W-1:0]   zero_point;
  logic        [SCALE_W-1:0] batch_scale;
  logic        [SCALE_W-1:0] channel_scale;
  logic signed [RES_W-1:0]   prior_result;

  modport source (
    output valid, matrix_value, vector_value, last_in_row, zero_point,
           batch_scale, channel_scale, prior_result,
    input  ready
  );
  modport sink (
    input  valid, matrix_value, vector_value, last_in_row, zero_point,
           batch_scale, channel_scale, prior_result,
    output ready
  );
endinterface

interface hmv_out_if import hmv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] new_result;
  logic signed [DOT_W-1:0] corrected_dot;

  modport source (output valid, new_result, corrected_dot, input ready);
  modport sink (input valid, new_result, corrected_dot, output ready);
endinterface

[src/hybrid_int8_matvec_offset_scale.sv]
// Int8 matrix-vector multiply-accumulate with offset correction and scaling.
// Top level: ties front, row queue and back end. Depends on hmv_pkg, hmv_if,
// hmv_front, hmv_fifo and hmv_back.
//
// Usage:
//   item   - valid/ready channel of (matrix, vector) int8 pairs. last_in_row
//            closes a row; offset, scales and prior result are sampled only
//            on that transaction.
//   result - valid/ready channel, one transaction per closed row, carrying
//            the saturated Q39.24 result and the corrected dot product.
//   cfg_we/cfg_wdata - write use_channel_scale; write only while idle.
// Throughput: one pair per cycle. The multiply-accumulate front end takes a
// pair every cycle as long as the row queue has room; the queue fills only
// when rows close faster than the back end drains them.
// The back end takes one row at a time through its correct, scale, multiply,
// add and output states. While result.ready is low the back end holds its
// result and the queue absorbs up to QUEUE_DEPTH further rows before
// item.ready drops.
// Reset clears the accumulators, the queue and use_channel_scale.
module hybrid_int8_matvec_offset_scale import hmv_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  hmv_in_if.sink     item,
  hmv_out_if.source  result
);

  logic           use_channel_scale;
  logic           q_push;
  logic           q_pop;
  hmv_row_t       q_wr_data;
  hmv_row_t       q_rd_data;
  hmv_fifo_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_channel_scale <= 1'b0;
    end else if (cfg_we) begin
      use_channel_scale <= cfg_wdata;
    end
  end

  hmv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  hmv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  hmv_back u_back (
    .clk               (clk),
    .rst               (rst),
    .use_channel_scale (use_channel_scale),
    .q_stat            (q_stat),
    .q_data            (q_rd_data),
    .q_pop             (q_pop),
    .result            (result)
  );

endmodule

[src/hmv_front.sv]
// Front end: accepts pairs, runs the dot-product and row-sum accumulators,
// and pushes each closed row into the queue. Depends on hmv_pkg and hmv_if.
module hmv_front import hmv_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  hmv_in_if.sink         item,
  input  hmv_fifo_stat_t q_stat,
  output logic           q_push,
  output hmv_row_t       q_data
);

  logic signed [DOT_W-1:0]   dot_acc;
  logic signed [DOT_W-1:0]   dot_next;
  logic signed [SUM_W-1:0]   row_sum_acc;
  logic signed [SUM_W-1:0]   row_sum_next;
  logic signed [2*VAL_W-1:0] pair_prod;
  logic                      accept;

  assign item.ready = !q_stat.full;
  assign accept     = item.valid && item.ready;

  assign pair_prod    = (2*VAL_W)'(item.matrix_value) * (2*VAL_W)'(item.vector_value);
  // Accumulators wrap within their widths on overlong rows
  assign dot_next     = dot_acc
                      + {{(DOT_W-2*VAL_W){pair_prod[2*VAL_W-1]}}, pair_prod};
  assign row_sum_next = row_sum_acc
                      + {{(SUM_W-VAL_W){item.matrix_value[VAL_W-1]}}, item.matrix_value};

  assign q_push = accept && item.last_in_row;

  always_comb begin
    q_data.dot           = dot_next;
    q_data.row_sum       = row_sum_next;
    q_data.zero_point    = item.zero_point;
    q_data.batch_scale   = item.batch_scale;
    q_data.channel_scale = item.channel_scale;
    q_data.prior_result  = item.prior_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc     <= '0;
      row_sum_acc <= '0;
    end else if (accept) begin
      if (item.last_in_row) begin
        dot_acc     <= '0;
        row_sum_acc <= '0;
      end else begin
        dot_acc     <= dot_next;
        row_sum_acc <= row_sum_next;
      end
    end
  end

  a_clear_after_row: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (dot_acc == '0) && (row_sum_acc == '0))
    else $error("accumulators not cleared after row close");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(dot_acc) && $stable(row_sum_acc))
    else $error("accumulators moved without a transaction");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("row pushed into a full queue");

endmodule

[src/hmv_fifo.sv]
// Short row queue between the accumulator front and the scaling back end.
// Depends on hmv_pkg.
module hmv_fifo import hmv_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hmv_row_t       wr_data,
  input  logic           pop,
  output hmv_row_t       rd_data,
  output hmv_fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hmv_row_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign rd_data    = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_adv(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_adv(rd_ptr);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty))
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

[src/hmv_back.sv]
// Back end: takes one closed row at a time, applies the offset correction,
// builds the scale, scales and saturates. Depends on hmv_pkg and hmv_if.
module hmv_back import hmv_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           use_channel_scale,
  input  hmv_fifo_stat_t q_stat,
  input  hmv_row_t       q_data,
  output logic           q_pop,
  hmv_out_if.source      result
);

  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic [2*SCALE_W-1:0]    HALF_LSB = (2*SCALE_W)'(1) << (SCALE_FRAC_BITS - 1);

  hmv_back_state_t state;
  hmv_back_state_t state_next;

  hmv_row_t                  row;
  logic signed [DOT_W-1:0]   corr;
  logic [2*SCALE_W-1:0]      scale_prod;
  logic [SCALE_W-1:0]        scale;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RES_W-1:0]   new_result;

  logic signed [RSO_W-1:0]   rs_off;
  logic signed [CORR_W-1:0]  corr_wide;
  logic [CORR_W-DOT_W:0]     corr_top;
  logic signed [DOT_W-1:0]   corr_sat;
  logic [2*SCALE_W-1:0]      scale_rnd;
  logic [SCALE_W-1:0]        scale_sel;
  logic signed [RES_W-1:0]   prod_ext;
  logic signed [RES_W-1:0]   sum;
  logic signed [RES_W-1:0]   sum_sat;

  // Offset correction, saturated to the accumulator width
  assign rs_off    = RSO_W'($signed(row.row_sum)) * RSO_W'($signed(row.zero_point));
  assign corr_wide = CORR_W'($signed(row.dot)) - CORR_W'(rs_off);
  assign corr_top  = corr_wide[CORR_W-1:DOT_W-1];

  always_comb begin
    if ((&corr_top) || !(|corr_top)) begin
      corr_sat = corr_wide[DOT_W-1:0];
    end else if (corr_wide[CORR_W-1]) begin
      corr_sat = DOT_MIN;
    end else begin
      corr_sat = DOT_MAX;
    end
  end

  // Combined scale: round half up to the scale fraction, clamp to all ones
  assign scale_rnd = (scale_prod + HALF_LSB) >> SCALE_FRAC_BITS;

  always_comb begin
    if (!use_channel_scale) begin
      scale_sel = row.batch_scale;
    end else if (|scale_rnd[2*SCALE_W-1:SCALE_W]) begin
      scale_sel = '1;
    end else begin
      scale_sel = scale_rnd[SCALE_W-1:0];
    end
  end

  assign prod_ext = RES_W'(prod);
  assign sum      = row.prior_result + prod_ext;

  always_comb begin
    if (!row.prior_result[RES_W-1] && !prod_ext[RES_W-1] && sum[RES_W-1]) begin
      sum_sat = RES_MAX;
    end else if (row.prior_result[RES_W-1] && prod_ext[RES_W-1] && !sum[RES_W-1]) begin
      sum_sat = RES_MIN;
    end else begin
      sum_sat = sum;
    end
  end

  always_comb begin
    case (state)
      B_IDLE:  state_next = q_stat.empty ? B_IDLE : B_CORR;
      B_CORR:  state_next = B_SCALE;
      B_SCALE: state_next = B_PROD;
      B_PROD:  state_next = B_SUM;
      B_SUM:   state_next = B_OUT;
      B_OUT:   state_next = result.ready ? B_IDLE : B_OUT;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    result.valid = 1'b0;
    case (state)
      B_IDLE:  q_pop = !q_stat.empty;
      B_OUT:   result.valid = 1'b1;
      default: begin
        q_pop        = 1'b0;
        result.valid = 1'b0;
      end
    endcase
  end

  assign result.new_result    = new_result;
  assign result.corrected_dot = corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          row <= q_data;
        end
      end
      B_CORR: begin
        corr       <= corr_sat;
        scale_prod <= (2*SCALE_W)'(row.batch_scale) * (2*SCALE_W)'(row.channel_scale);
      end
      B_SCALE: scale <= scale_sel;
      B_PROD:  prod <= PROD_W'(corr) * PROD_W'($signed({1'b0, scale}));
      B_SUM:   new_result <= sum_sat;
      default: ;
    endcase
  end

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("row popped from an empty queue");

  a_one_result_per_row: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready |=> !result.valid)
    else $error("result repeated after transaction");

  a_zero_corr_passes_prior: assert property (@(posedge clk) disable iff (rst)
    result.valid && (corr == '0) |-> result.new_result == row.prior_result)
    else $error("zero correction changed the prior result");

  a_plain_scale: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCALE) && !use_channel_scale |=> scale == row.batch_scale)
    else $error("batch scale altered with channel scale off");

endmodule

[tb/sv/tb_hybrid_int8_matvec_offset_scale.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hybrid_int8_matvec_offset_scale: int8 pair stream in, row results out.
// Depends on hmv_pkg and the hmv_in_if / hmv_out_if channel interfaces.
module tb_hybrid_int8_matvec_offset_scale import hmv_pkg::*; ();

  localparam int     QUIET_LIMIT  = 2000;
  localparam int     SETTLE_CYC   = 12;
  localparam int     MAX_REPORTS  = 10;
  localparam longint RES_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint RES_MIN      = 64'sh8000_0000_0000_0000;
  localparam longint CORR_HI      = (longint'(1) << (DOT_W - 1)) - 1;
  localparam longint CORR_LO      = -(longint'(1) << (DOT_W - 1));
  localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 32'hFFFF_FFFF;
  localparam logic [63:0]        ROUND_HALF = 64'd1 << (SCALE_FRAC_BITS - 1);

  typedef struct {
    logic signed [VAL_W-1:0]   matrix_value;
    logic signed [VAL_W-1:0]   vector_value;
    logic                      last_in_row;
    logic signed [VAL_W-1:0]   zero_point;
    logic        [SCALE_W-1:0] batch_scale;
    logic        [SCALE_W-1:0] channel_scale;
    logic signed [RES_W-1:0]   prior_result;
  } pair_t;

  typedef struct {
    logic signed [RES_W-1:0] new_result;
    logic signed [DOT_W-1:0] corrected_dot;
  } row_result_t;

  typedef enum int {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HALF,
    SINK_BURSTY
  } sink_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  hmv_in_if  item_ch ();
  hmv_out_if res_ch ();

  hybrid_int8_matvec_offset_scale dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch)
  );

  always #10 clk = ~clk;

  pair_t       pending_pairs[$];
  row_result_t due_results[$];

  // Mirror of the block's accumulators and register
  logic signed [DOT_W-1:0] dot_acc     = '0;
  logic signed [SUM_W-1:0] row_sum_acc = '0;
  bit                      chan_scale_on = 1'b0;

  int error_count    = 0;
  int pairs_taken    = 0;
  int rows_checked   = 0;
  int sat_sum_rows   = 0;
  int clamped_rows   = 0;
  int quiet_cycles   = 0;

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Advance the accumulators by one pair; on a closing pair, compute the row result.
  function automatic void accumulate_pair(input pair_t p);
    longint      corr;
    longint      prod;
    longint      total;
    logic [63:0] scale;
    logic [63:0] wide;
    row_result_t r;
    dot_acc = DOT_W'(longint'(dot_acc) +
                     longint'(p.matrix_value) * longint'(p.vector_value));
    row_sum_acc = SUM_W'(longint'(row_sum_acc) + longint'(p.matrix_value));
    if (!p.last_in_row) return;

    corr = longint'(dot_acc) - longint'(row_sum_acc) * longint'(p.zero_point);
    if (corr > CORR_HI) begin
      corr = CORR_HI;
      clamped_rows++;
    end else if (corr < CORR_LO) begin
      corr = CORR_LO;
      clamped_rows++;
    end

    scale = {32'b0, p.batch_scale};
    if (chan_scale_on) begin
      wide = scale * {32'b0, p.channel_scale};
      wide = (wide + ROUND_HALF) >> SCALE_FRAC_BITS;
      scale = (wide > {32'b0, SCALE_MAX}) ? {32'b0, SCALE_MAX} : wide;
    end

    prod  = corr * longint'(scale);
    total = longint'(p.prior_result) + prod;
    if (p.prior_result >= 0 && prod >= 0 && total < 0) begin
      total = RES_MAX;
      sat_sum_rows++;
    end else if (p.prior_result < 0 && prod < 0 && total >= 0) begin
      total = RES_MIN;
      sat_sum_rows++;
    end

    r.new_result    = total;
    r.corrected_dot = DOT_W'(corr);
    due_results.push_back(r);
    dot_acc     = '0;
    row_sum_acc = '0;
  endfunction

  // Driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_pairs
    pair_t p;
    pair_t taken;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        taken.matrix_value  = item_ch.matrix_value;
        taken.vector_value  = item_ch.vector_value;
        taken.last_in_row   = item_ch.last_in_row;
        taken.zero_point    = item_ch.zero_point;
        taken.batch_scale   = item_ch.batch_scale;
        taken.channel_scale = item_ch.channel_scale;
        taken.prior_result  = item_ch.prior_result;
        accumulate_pair(taken);
        pairs_taken++;
      end
      if (item_ch.valid && !item_ch.ready) begin
        // hold the transaction until it is taken
      end else if (gap_left != 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        p = pending_pairs.pop_front();
        item_ch.valid         <= 1'b1;
        item_ch.matrix_value  <= p.matrix_value;
        item_ch.vector_value  <= p.vector_value;
        item_ch.last_in_row   <= p.last_in_row;
        item_ch.zero_point    <= p.zero_point;
        item_ch.batch_scale   <= p.batch_scale;
        item_ch.channel_scale <= p.channel_scale;
        item_ch.prior_result  <= p.prior_result;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transaction and drive ready on a changing pattern
  sink_mode_t sink_mode  = SINK_OPEN;
  int         sink_left  = 0;
  int         stall_run  = 0;

  always @(posedge clk) begin : check_results
    row_result_t want;
    logic        rdy;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          flag_error($sformatf("unexpected result: new_result %0d corrected_dot %0d",
                               res_ch.new_result, res_ch.corrected_dot));
        end else begin
          want = due_results.pop_front();
          if (res_ch.new_result !== want.new_result)
            flag_error($sformatf("row %0d new_result: expected %0d, got %0d",
                                 rows_checked, want.new_result, res_ch.new_result));
          if (res_ch.corrected_dot !== want.corrected_dot)
            flag_error($sformatf("row %0d corrected_dot: expected %0d, got %0d",
                                 rows_checked, want.corrected_dot, res_ch.corrected_dot));
          rows_checked++;
        end
      end

      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(20, 120);
      end
      sink_left--;
      case (sink_mode)
        SINK_OPEN:  rdy = 1'b1;
        SINK_LIGHT: rdy = ($urandom_range(0, 3) != 0);
        SINK_HALF:  rdy = ($urandom_range(0, 1) != 0);
        default: begin
          if (stall_run != 0) begin
            stall_run--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 2) == 0) stall_run = $urandom_range(5, 25);
          end
        end
      endcase
      res_ch.ready <= rdy;
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results still due",
                 QUIET_LIMIT, due_results.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic void queue_pair(input logic signed [VAL_W-1:0] m,
                                     input logic signed [VAL_W-1:0] v,
                                     input logic last,
                                     input logic signed [VAL_W-1:0] off,
                                     input logic [SCALE_W-1:0] bs,
                                     input logic [SCALE_W-1:0] cs,
                                     input logic signed [RES_W-1:0] prior);
    pair_t p;
    p.matrix_value  = m;
    p.vector_value  = v;
    p.last_in_row   = last;
    p.zero_point    = off;
    p.batch_scale   = bs;
    p.channel_scale = cs;
    p.prior_result  = prior;
    pending_pairs.push_back(p);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return -128;
      1:       return 127;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SCALE_MAX;
      2:       return $urandom_range(0, 32'h0200_0000);
      3:       return SCALE_ONE + $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [RES_W-1:0] rand_prior();
    case ($urandom_range(0, 5))
      0:       return RES_MAX;
      1:       return RES_MIN;
      2:       return longint'(int'($urandom));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void queue_random_row(input int len);
    logic signed [VAL_W-1:0] off;
    for (int i = 0; i < len; i++) begin
      off = ($urandom_range(0, 3) == 0) ? '0 : rand_byte();
      queue_pair(rand_byte(), rand_byte(), i == len - 1, off, rand_scale(), rand_scale(),
                 rand_prior());
    end
  endfunction

  // Long row: n copies of one pair, then balancing pairs that grow the dot product
  // while leaving the row sum alone, then a zero closing pair.
  function automatic void queue_long_row(input logic signed [VAL_W-1:0] m,
                                         input logic signed [VAL_W-1:0] v,
                                         input int n,
                                         input logic signed [VAL_W-1:0] bm,
                                         input logic signed [VAL_W-1:0] bv,
                                         input int n_bal,
                                         input logic signed [VAL_W-1:0] off);
    for (int i = 0; i < n; i++)
      queue_pair(m, v, 1'b0, rand_byte(), rand_scale(), rand_scale(), rand_prior());
    for (int i = 0; i < n_bal; i++) begin
      queue_pair(bm, bv, 1'b0, rand_byte(), rand_scale(), rand_scale(), rand_prior());
      queue_pair(-bm, -bv, 1'b0, rand_byte(), rand_scale(), rand_scale(), rand_prior());
    end
    queue_pair(0, 0, 1'b1, off, SCALE_ONE, rand_scale(), rand_prior());
  endfunction

  // Wait until every queued pair is taken and every row result has arrived
  task automatic drain();
    do @(posedge clk);
    while (pending_pairs.size() != 0 || item_ch.valid || due_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_channel_scaling(input bit on);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= on;
    chan_scale_on = on;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int count;
    int len;
    clk                   = 1'b0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = 1'b0;
    item_ch.valid         = 1'b0;
    item_ch.matrix_value  = '0;
    item_ch.vector_value  = '0;
    item_ch.last_in_row   = 1'b0;
    item_ch.zero_point    = '0;
    item_ch.batch_scale   = '0;
    item_ch.channel_scale = '0;
    item_ch.prior_result  = '0;
    res_ch.ready          = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Channel scale off (reset value): extremes, saturation both ways, absent offset
    queue_pair(-128, -128, 1'b1, 0, SCALE_ONE, rand_scale(), 0);
    queue_pair(127, 127, 1'b0, 55, 32'h1234_5678, 32'h9ABC_DEF0, 64'sd77);
    queue_pair(-128, 127, 1'b1, -128, SCALE_MAX, SCALE_MAX, RES_MIN);
    queue_pair(-128, -128, 1'b1, 127, SCALE_MAX, 0, 64'sh7FFF_FFFF_FFFF_0000);
    queue_pair(127, -128, 1'b1, 127, SCALE_MAX, SCALE_MAX, RES_MIN + 5);
    queue_pair(0, 0, 1'b1, 0, 0, SCALE_MAX, RES_MAX);
    queue_pair(0, 0, 1'b1, -128, 32'h0000_FFFF, 0, RES_MIN);
    queue_pair(3, -7, 1'b0, -99, SCALE_MAX, SCALE_MAX, RES_MAX);
    queue_pair(-50, 90, 1'b0, 101, 0, 0, RES_MIN);
    queue_pair(12, 11, 1'b1, 0, SCALE_ONE, SCALE_MAX, -64'sd1000);
    drain();

    // Channel scale on: combined scale saturation, unity, round-half-up
    set_channel_scaling(1'b1);
    queue_pair(-128, -128, 1'b1, 127, SCALE_MAX, SCALE_MAX, 0);
    queue_pair(5, 7, 1'b1, 3, SCALE_ONE, SCALE_ONE, 64'sd12345);
    queue_pair(1, 1, 1'b1, 0, 32'd1, 32'h0080_0000, 0);
    queue_pair(1, 1, 1'b1, 0, 32'd1, 32'h007F_FFFF, 0);
    queue_pair(100, -100, 1'b1, -5, 0, SCALE_MAX, 64'sd9);
    queue_pair(-128, 127, 1'b1, -128, 32'h0300_0000, 32'h8000_0000, RES_MIN);
    queue_pair(127, 127, 1'b1, 127, SCALE_MAX, 32'h0100_0001, RES_MAX - 10);
    drain();

    // Longer rows: large dot products of both signs and large negative row sums
    set_channel_scaling(1'b0);
    queue_long_row(-128, -128, 100, 127, 127, 5, 127);
    queue_long_row(-128, 127, 100, 127, -127, 5, -128);
    drain();

    // Random rows, alternating the register setting per phase
    for (int ph = 0; ph < 4; ph++) begin
      set_channel_scaling(ph % 2 == 0);
      count = 0;
      while (count < 50) begin
        case ($urandom_range(0, 9))
          0:             len = $urandom_range(17, 48);
          1, 2, 3:       len = $urandom_range(5, 16);
          default:       len = $urandom_range(1, 4);
        endcase
        queue_random_row(len);
        count += len;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d row results never arrived", due_results.size()));

    $display("Covered %0d pairs in %0d rows with channel scaling off and on,",
             pairs_taken, rows_checked);
    $display("including %0d saturated sums and %0d clamped corrections; %0d errors.",
             sat_sum_rows, clamped_rows, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
